// File: hw/rtl/frustum_visibility_classifier_defines.svh
`ifndef FRUSTUM_VISIBILITY_CLASSIFIER_DEFINES_SVH
`define FRUSTUM_VISIBILITY_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define FVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fvc_pkg.sv
package fvc_pkg;

    localparam int unsigned COORD_W   = 16;
    localparam int unsigned RADIUS_W  = 15;
    localparam int unsigned PROD_W    = 32;
    localparam int unsigned DIST_W    = 34;
    localparam int unsigned FRAC_SH   = 14;
    localparam int unsigned PLANE_W   = 64;
    localparam int unsigned REG_COUNT = 6;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [1:0] OP_POINT  = 2'd0;
    localparam logic [1:0] OP_SPHERE = 2'd1;
    localparam logic [1:0] OP_BOX    = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic [1:0] VERDICT_OUT   = 2'd0;
    localparam logic [1:0] VERDICT_CROSS = 2'd1;
    localparam logic [1:0] VERDICT_IN    = 2'd2;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [COORD_W-1:0]  lo_x;
        logic signed [COORD_W-1:0]  lo_y;
        logic signed [COORD_W-1:0]  lo_z;
        logic signed [COORD_W-1:0]  hi_x;
        logic signed [COORD_W-1:0]  hi_y;
        logic signed [COORD_W-1:0]  hi_z;
        logic [RADIUS_W-1:0]        radius;
    } t_query;

    typedef struct packed {
        logic       done;
        logic [1:0] verdict;
        logic       all_in;
    } t_status;

    function automatic logic signed [PROD_W-1:0] smax(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [PROD_W-1:0] smin(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [DIST_W-1:0] sext(input logic signed [PROD_W-1:0] v);
        return DIST_W'(v);
    endfunction

endpackage

// File: hw/rtl/frustum_visibility_classifier.sv
// channel   | dir | tdata (low bit up)                                  | tuser
// ----------+-----+------------------------------------------------------+--------
// s_axis    | in  | x_first, y_first, z_first, x_second, y_second,       | opcode
//           |     | z_second, sphere_radius, 1 pad bit (112)             |
// m_axis    | out | verdict, 6 pad bits (8)                              | -
// cfg write | in  | i_cfg_index selects plane, i_cfg_data is the plane   | -
//
// One word per cycle sustained while the output is not stalled; the path runs
// through the chain of plane cells (multiply stage, then sum/compare stage per
// plane) and then the output register.
// Every stage fills independently, so a stalled output still lets words in
// until the chain is full. Synchronous active-low reset empties the chain
// and clears the planes to zero.
`include "frustum_visibility_classifier_defines.svh"

module frustum_visibility_classifier
    import fvc_pkg::*;
#(
    parameter int unsigned PLANE_COUNT = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PLANE_W-1:0]   i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // x_first, y_first, z_first, x_second, y_second, z_second, sphere_radius
    input  logic [111:0]         s_axis_tdata,
    // opcode
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // verdict
    output logic [7:0]           m_axis_tdata
);

    logic [PLANE_W-1:0] r_plane [PLANE_COUNT];

    logic    w_valid  [PLANE_COUNT+1];
    logic    w_ready  [PLANE_COUNT+1];
    t_query  w_query  [PLANE_COUNT+1];
    t_status w_status [PLANE_COUNT+1];

    logic       r_out_valid;
    logic [1:0] r_out_verdict;
    logic [1:0] r_out_op;
    logic [1:0] n_out_verdict;
    logic       en_out;

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[p] <= '0;
            end else if (i_cfg_we && (p < REG_COUNT) && i_cfg_index == CFG_IDX_W'(p)) begin
                r_plane[p] <= i_cfg_data;
            end
        end

        fvc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_plane  (r_plane[p]),
            .i_valid  (w_valid[p]),
            .o_ready  (w_ready[p]),
            .i_query  (w_query[p]),
            .i_status (w_status[p]),
            .o_valid  (w_valid[p+1]),
            .i_ready  (w_ready[p+1]),
            .o_query  (w_query[p+1]),
            .o_status (w_status[p+1])
        );
    end

    assign w_valid[0]         = s_axis_tvalid;
    assign s_axis_tready      = w_ready[0];
    assign w_query[0].op      = s_axis_tuser;
    assign w_query[0].lo_x    = s_axis_tdata[15:0];
    assign w_query[0].lo_y    = s_axis_tdata[31:16];
    assign w_query[0].lo_z    = s_axis_tdata[47:32];
    assign w_query[0].hi_x    = s_axis_tdata[63:48];
    assign w_query[0].hi_y    = s_axis_tdata[79:64];
    assign w_query[0].hi_z    = s_axis_tdata[95:80];
    assign w_query[0].radius  = s_axis_tdata[110:96];
    assign w_status[0].done    = (s_axis_tuser == OP_RSVD);
    assign w_status[0].verdict = VERDICT_OUT;
    assign w_status[0].all_in  = 1'b1;

    assign en_out              = !r_out_valid || m_axis_tready;
    assign w_ready[PLANE_COUNT] = en_out;

    always_comb begin
        if (w_status[PLANE_COUNT].done) begin
            n_out_verdict = w_status[PLANE_COUNT].verdict;
        end else if (w_query[PLANE_COUNT].op == OP_BOX && !w_status[PLANE_COUNT].all_in) begin
            n_out_verdict = VERDICT_CROSS;
        end else begin
            n_out_verdict = VERDICT_IN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= w_valid[PLANE_COUNT];
        end
        if (en_out) begin
            r_out_verdict <= n_out_verdict;
            r_out_op      <= w_query[PLANE_COUNT].op;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_verdict};

    `FVC_ASSERT_NOW(a_verdict_code, i_clk, i_rst_n, r_out_valid, r_out_verdict != 2'd3, "verdict code out of range")
    `FVC_ASSERT_NOW(a_point_binary, i_clk, i_rst_n, r_out_valid && r_out_op == OP_POINT, r_out_verdict != VERDICT_CROSS, "point query gave intersecting")
    `FVC_ASSERT_NOW(a_rsvd_outside, i_clk, i_rst_n, r_out_valid && r_out_op == OP_RSVD, r_out_verdict == VERDICT_OUT, "unused opcode not outside")
    `FVC_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !r_out_valid, s_axis_tready, "input stalled with empty output")

endmodule

// File: hw/rtl/fvc_cell.sv
module fvc_cell
    import fvc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PLANE_W-1:0]  i_plane,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_query              i_query,
    input  t_status             i_status,
    output logic                o_valid,
    input  logic                i_ready,
    output t_query              o_query,
    output t_status             o_status
);

    logic signed [COORD_W-1:0] w_a, w_b, w_c;

    logic                      r_va;
    t_query                    r_qa;
    t_status                   r_sa;
    logic signed [COORD_W-1:0] r_d;
    logic signed [PROD_W-1:0]  r_plx, r_ply, r_plz, r_phx, r_phy, r_phz;

    logic                      r_vb;
    t_query                    r_qb;
    t_status                   r_sb;
    t_status                   n_sb;

    logic en_a, en_b;

    logic signed [DIST_W-1:0] w_d14, w_rs, w_dist, w_dmax, w_dmin;

    assign w_a = i_plane[15:0];
    assign w_b = i_plane[31:16];
    assign w_c = i_plane[47:32];

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_query = r_qb;
    assign o_status = r_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en_a) begin
            r_va <= i_valid;
        end
        if (en_a) begin
            r_qa  <= i_query;
            r_sa  <= i_status;
            r_d   <= i_plane[63:48];
            r_plx <= w_a * i_query.lo_x;
            r_ply <= w_b * i_query.lo_y;
            r_plz <= w_c * i_query.lo_z;
            r_phx <= w_a * i_query.hi_x;
            r_phy <= w_b * i_query.hi_y;
            r_phz <= w_c * i_query.hi_z;
        end
    end

    assign w_d14  = {{(DIST_W-COORD_W-FRAC_SH){r_d[COORD_W-1]}}, r_d, {FRAC_SH{1'b0}}};
    assign w_rs   = {{(DIST_W-RADIUS_W-FRAC_SH){1'b0}}, r_qa.radius, {FRAC_SH{1'b0}}};
    assign w_dist = sext(r_plx) + sext(r_ply) + sext(r_plz) + w_d14;
    assign w_dmax = sext(smax(r_plx, r_phx)) + sext(smax(r_ply, r_phy))
                  + sext(smax(r_plz, r_phz)) + w_d14;
    assign w_dmin = sext(smin(r_plx, r_phx)) + sext(smin(r_ply, r_phy))
                  + sext(smin(r_plz, r_phz)) + w_d14;

    always_comb begin
        n_sb = r_sa;
        if (!r_sa.done) begin
            case (r_qa.op)
                OP_POINT: begin
                    if (w_dist <= 0) begin
                        n_sb.done    = 1'b1;
                        n_sb.verdict = VERDICT_OUT;
                    end
                end
                OP_SPHERE: begin
                    if (w_dist < -w_rs) begin
                        n_sb.done    = 1'b1;
                        n_sb.verdict = VERDICT_OUT;
                    end else if (w_dist > -w_rs && w_dist < w_rs) begin
                        n_sb.done    = 1'b1;
                        n_sb.verdict = VERDICT_CROSS;
                    end
                end
                OP_BOX: begin
                    if (w_dmax < 0) begin
                        n_sb.done    = 1'b1;
                        n_sb.verdict = VERDICT_OUT;
                    end else if (w_dmin < 0) begin
                        n_sb.all_in = 1'b0;
                    end
                end
                default: begin
                    n_sb.done    = 1'b1;
                    n_sb.verdict = VERDICT_OUT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en_b) begin
            r_vb <= r_va;
        end
        if (en_b) begin
            r_qb <= r_qa;
            r_sb <= n_sb;
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fvc_pkg::*;

    localparam int NUM_PLANES      = 6;
    localparam int NUM_CORNERS     = 8;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int TAIL_CYCLES     = 2 * NUM_PLANES + 8;

    typedef struct {
        t_query     q;
        bit         reload;
        bit         typed;
        logic [1:0] verdict;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [PLANE_W-1:0]   i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [111:0]         s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;

    logic [PLANE_W-1:0] plane_regs[NUM_PLANES] = '{default: '0};
    logic [PLANE_W-1:0] plane_plan[NUM_PLANES];
    logic [1:0]         pending_verdicts[$];
    t_directed_row      directed_rows[$];
    logic [15:0]        stall_pattern = 16'hFFFF;
    logic [3:0]         stall_pos     = '0;
    int unsigned        cycle_count   = 0;
    int                 mismatch_count = 0;

    frustum_visibility_classifier #(
        .PLANE_COUNT(NUM_PLANES)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= stall_pattern[stall_pos];
        stall_pos     <= stall_pos + 1'b1;
    end

    always @(posedge i_clk) begin : check_verdicts
        logic [1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict: no word expected, got %0d", m_axis_tdata[1:0]);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== want) begin
                    $error("verdict: expected %0d, got %0d", want, m_axis_tdata[1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic longint plane_distance(int p, longint x, longint y, longint z);
        logic [PLANE_W-1:0] w;
        longint a, b, c, d;
        w = plane_regs[p];
        a = $signed(w[15:0]);
        b = $signed(w[31:16]);
        c = $signed(w[47:32]);
        d = $signed(w[63:48]);
        return a * x + b * y + c * z + (d <<< FRAC_SH);
    endfunction

    function automatic logic [1:0] predict_verdict(t_query q);
        longint lo[3], hi[3];
        longint sdist, rs, mag;
        int p, k, neg;
        bit all_in;
        lo[0] = $signed(q.lo_x);
        lo[1] = $signed(q.lo_y);
        lo[2] = $signed(q.lo_z);
        hi[0] = $signed(q.hi_x);
        hi[1] = $signed(q.hi_y);
        hi[2] = $signed(q.hi_z);
        case (q.op)
            OP_POINT: begin
                for (p = 0; p < NUM_PLANES; p++)
                    if (plane_distance(p, lo[0], lo[1], lo[2]) <= 0)
                        return VERDICT_OUT;
                return VERDICT_IN;
            end
            OP_SPHERE: begin
                rs = longint'(q.radius) << FRAC_SH;
                for (p = 0; p < NUM_PLANES; p++) begin
                    sdist = plane_distance(p, lo[0], lo[1], lo[2]);
                    mag   = (sdist < 0) ? -sdist : sdist;
                    if (sdist < -rs)
                        return VERDICT_OUT;
                    if (mag < rs)
                        return VERDICT_CROSS;
                end
                return VERDICT_IN;
            end
            OP_BOX: begin
                all_in = 1'b1;
                for (p = 0; p < NUM_PLANES; p++) begin
                    neg = 0;
                    for (k = 0; k < NUM_CORNERS; k++) begin
                        sdist = plane_distance(p, k[0] ? hi[0] : lo[0],
                                               k[1] ? hi[1] : lo[1],
                                               k[2] ? hi[2] : lo[2]);
                        if (sdist < 0)
                            neg++;
                    end
                    if (neg == NUM_CORNERS)
                        return VERDICT_OUT;
                    if (neg != 0)
                        all_in = 1'b0;
                end
                return all_in ? VERDICT_IN : VERDICT_CROSS;
            end
            default: return VERDICT_OUT;
        endcase
    endfunction

    function automatic logic [PLANE_W-1:0] make_plane(logic [15:0] a, logic [15:0] b,
                                                       logic [15:0] c, logic [15:0] d);
        return {d, c, b, a};
    endfunction

    function automatic logic [15:0] pick_coord(int span);
        if (span == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int span, roll, ext, i, v;
        logic [15:0] lo3[3], hi3[3], tmp;
        case ($urandom_range(0, 3))
            0: span = 0;
            1: span = 8192;
            2: span = 2048;
            default: span = 256;
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 5)
            q.op = OP_RSVD;
        else if (roll < 37)
            q.op = OP_POINT;
        else if (roll < 69)
            q.op = OP_SPHERE;
        else
            q.op = OP_BOX;
        for (i = 0; i < 3; i++) begin
            lo3[i] = pick_coord(span);
            hi3[i] = pick_coord(0);
        end
        // ordered boxes mostly; a few stay fully random or get one axis inverted
        if (q.op == OP_BOX && $urandom_range(0, 9) != 0) begin
            ext = (span == 0) ? 32767 : 2 * span;
            for (i = 0; i < 3; i++) begin
                v = int'($signed(lo3[i])) + int'($urandom_range(0, ext));
                hi3[i] = (v > 32767) ? 16'h7FFF : 16'(v);
            end
            if ($urandom_range(0, 9) == 0) begin
                tmp    = lo3[0];
                lo3[0] = hi3[0];
                hi3[0] = tmp;
            end
        end
        q.lo_x = lo3[0];
        q.lo_y = lo3[1];
        q.lo_z = lo3[2];
        q.hi_x = hi3[0];
        q.hi_y = hi3[1];
        q.hi_z = hi3[2];
        case ($urandom_range(0, 7))
            0: q.radius = '0;
            1: q.radius = 15'($urandom);
            default: q.radius = 15'($urandom_range(0, (span == 0) ? 8192 : span));
        endcase
        return q;
    endfunction

    task automatic add_row(bit reload, bit typed, logic [1:0] verdict, logic [1:0] op,
                           int lx, int ly, int lz, int hx, int hy, int hz, int r);
        t_directed_row row;
        row.reload   = reload;
        row.typed    = typed;
        row.verdict  = verdict;
        row.q.op     = op;
        row.q.lo_x   = 16'(lx);
        row.q.lo_y   = 16'(ly);
        row.q.lo_z   = 16'(lz);
        row.q.hi_x   = 16'(hx);
        row.q.hi_y   = 16'(hy);
        row.q.hi_z   = 16'(hz);
        row.q.radius = 15'(r);
        directed_rows.push_back(row);
    endtask

    task automatic wait_drain();
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // indexes past the plane count get junk; the block must ignore them
    task automatic load_planes();
        int idx;
        logic [PLANE_W-1:0] word;
        for (idx = 0; idx < (1 << CFG_IDX_W); idx++) begin
            word = (idx < NUM_PLANES) ? plane_plan[idx] : {$urandom, $urandom};
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(idx);
            i_cfg_data  <= word;
            if (idx < REG_COUNT && idx < NUM_PLANES)
                plane_regs[idx] = word;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(t_query q, logic [1:0] verdict);
        s_axis_tdata  <= {1'b0, q.radius, q.hi_z, q.hi_y, q.hi_x, q.lo_z, q.lo_y, q.lo_x};
        s_axis_tuser  <= q.op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_verdicts.push_back(verdict);
    endtask

    initial begin : stimulus
        int p, phase, n, kind, burst_left, burst_max;
        t_query q;

        // zero planes: every distance is zero
        add_row(0, 1, VERDICT_OUT,   OP_POINT,  0, 0, 0, 0, 0, 0, 0);
        add_row(0, 1, VERDICT_OUT,   OP_POINT,  32767, 32767, 32767,
                -32768, -32768, -32768, 32767);
        add_row(0, 1, VERDICT_OUT,   OP_POINT,  -32768, -32768, -32768, 0, 0, 0, 0);
        add_row(0, 1, VERDICT_IN,    OP_SPHERE, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 1, VERDICT_CROSS, OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767);
        add_row(0, 1, VERDICT_IN,    OP_BOX,    -32768, -32768, -32768,
                32767, 32767, 32767, 0);
        add_row(0, 1, VERDICT_OUT,   OP_RSVD,   100, 200, 300, 400, 500, 600, 77);
        // cube of +-10.0 around the origin
        add_row(1, 0, VERDICT_OUT,   OP_POINT,  0, 0, 0, 32767, 32767, 32767, 32767);
        add_row(0, 0, VERDICT_OUT,   OP_POINT,  2560, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, VERDICT_OUT,   OP_POINT,  0, -2561, 0, 0, 0, 0, 0);
        add_row(0, 0, VERDICT_OUT,   OP_SPHERE, 0, 0, 0, 0, 0, 0, 256);
        add_row(0, 0, VERDICT_OUT,   OP_SPHERE, 2500, 0, 0, 0, 0, 0, 256);
        add_row(0, 0, VERDICT_OUT,   OP_SPHERE, 0, 0, 3000, 0, 0, 0, 256);
        add_row(0, 0, VERDICT_OUT,   OP_SPHERE, 2560, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, VERDICT_OUT,   OP_SPHERE, 0, 2561, 0, 0, 0, 0, 0);
        add_row(0, 0, VERDICT_OUT,   OP_BOX,    -256, -256, -256, 256, 256, 256, 0);
        add_row(0, 0, VERDICT_OUT,   OP_BOX,    2000, -256, -256, 3000, 256, 256, 0);
        add_row(0, 0, VERDICT_OUT,   OP_BOX,    -256, -256, 3000, 256, 256, 4000, 0);
        add_row(0, 0, VERDICT_OUT,   OP_BOX,    256, 256, 256, -256, -256, -256, 0);
        add_row(0, 0, VERDICT_OUT,   OP_BOX,    3000, -256, -256, 0, 256, 256, 0);
        add_row(0, 0, VERDICT_OUT,   OP_BOX,    -32768, -32768, -32768,
                32767, 32767, 32767, 32767);
        add_row(0, 0, VERDICT_OUT,   OP_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767);
        add_row(0, 1, VERDICT_OUT,   OP_RSVD,   -1, -1, -1, -1, -1, -1, 32767);

        repeat (11) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        stall_pattern <= 16'hB6DB;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].reload) begin
                s_axis_tvalid <= 1'b0;
                wait_drain();
                plane_plan[0] = make_plane(16'hC000, 0, 0, 2560);
                plane_plan[1] = make_plane(16'h4000, 0, 0, 2560);
                plane_plan[2] = make_plane(0, 16'h4000, 0, 2560);
                plane_plan[3] = make_plane(0, 16'hC000, 0, 2560);
                plane_plan[4] = make_plane(0, 0, 16'hC000, 2560);
                plane_plan[5] = make_plane(0, 0, 16'h4000, 2560);
                load_planes();
            end
            send_word(directed_rows[i].q, directed_rows[i].typed ?
                      directed_rows[i].verdict : predict_verdict(directed_rows[i].q));
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            s_axis_tvalid <= 1'b0;
            wait_drain();
            stall_pattern <= (phase % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
            kind = $urandom_range(0, 3);
            for (p = 0; p < NUM_PLANES; p++) begin
                case (phase)
                    0: plane_plan[p] = 64'hFFFF_FFFF_FFFF_FFFF;
                    1: plane_plan[p] = 64'h7FFF_7FFF_7FFF_7FFF;
                    2: plane_plan[p] = 64'h8000_8000_8000_8000;
                    3: plane_plan[p] = '0;
                    default: begin
                        if (kind < 2) begin
                            plane_plan[p] = '0;
                            plane_plan[p][16 * (p / 2) +: 16] =
                                (p % 2 == 0) ? 16'hC000 : 16'h4000;
                            plane_plan[p][63:48] = 16'($urandom_range(256, 8192));
                        end else if (kind == 2) begin
                            plane_plan[p] = make_plane(
                                16'(int'($urandom_range(0, 32767)) - 16384),
                                16'(int'($urandom_range(0, 32767)) - 16384),
                                16'(int'($urandom_range(0, 32767)) - 16384),
                                16'($urandom_range(0, 16384)));
                        end else begin
                            plane_plan[p] = {$urandom, $urandom};
                        end
                    end
                endcase
            end
            load_planes();

            case ($urandom_range(0, 2))
                0: burst_max = 4;
                1: burst_max = 24;
                default: burst_max = 500;
            endcase
            burst_left = 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    s_axis_tvalid <= 1'b0;
                    if ($urandom_range(0, 19) == 0)
                        wait_drain();
                    else
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    burst_left = $urandom_range(1, burst_max);
                end
                burst_left--;
                q = rand_query();
                send_word(q, predict_verdict(q));
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
